// ----- src/cbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Colour map shading package
// Shared constants, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  localparam logic [31:0] SCALE_ONE_Q16 = 32'h0001_0000;
  localparam logic [32:0] BRIGHT_FULL   = 33'h1_0000_0000;

  typedef struct packed {
    logic in_ready;
    logic mul_colour;
    logic mul_bright;
    logic read_entry;
    logic emit;
  } cbs_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_pixel;
    logic out_free;
  } cbs_status_t;

endpackage

`default_nettype wire

// ----- src/cbs_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel interface
// Carries palette load items and pixel items with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbs_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_index;
  logic [7:0]  entry_red;
  logic [7:0]  entry_green;
  logic [7:0]  entry_blue;
  logic signed [31:0] colour_value;
  logic signed [31:0] bright_value;

  modport source (
    output valid, operation, entry_index, entry_red, entry_green, entry_blue,
           colour_value, bright_value,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_index, entry_red, entry_green, entry_blue,
           colour_value, bright_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/cbs_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel interface
// Carries shaded pixel items with their position and the frame end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] column;
  logic [15:0] row;
  logic        frame_end;

  modport source (
    output valid, red, green, blue, column, row, frame_end,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, column, row, frame_end,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/cbs_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/colormap_brightness_shade.sv -----
// ----------------------------------------------------------------------------
// Colour map brightness shading
// Palette lookup of a scaled colour value, shaded by a scaled brightness.
// ----------------------------------------------------------------------------
// A palette load item is accepted while the controller is idle; one load
// item per cycle while no pixel item is in progress. A pixel item is scaled
// on the shared scaling multiplier (two passes), read from the registered
// palette and shaded; no new item is taken until its result is emitted.
// Synchronous active-low reset clears the registers to their defaults and the
// position counters to zero; palette contents are undefined until loaded.
`default_nettype none

module colormap_brightness_shade (
  input  wire logic clk,
  input  wire logic rst_n,
  cbs_cfg_if.sink   cfg_s,
  cbs_in_if.sink    in_s,
  cbs_out_if.source out_s
);
  import cbs_pkg::*;

  cbs_cmd_t    cmd;
  cbs_status_t st;

  cbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  cbs_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .in_s  (in_s),
    .out_s (out_s),
    .cmd   (cmd),
    .st    (st)
  );

endmodule

`default_nettype wire

// ----- src/cbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Colour map shading controller
// Sequences the datapath through the two scalings, the palette read and the
// shading of one pixel item.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cbs_pkg::cbs_status_t st,
  output cbs_pkg::cbs_cmd_t         cmd
);
  import cbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_C,
    ST_MUL_B,
    ST_READ,
    ST_SHADE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid && st.is_pixel) begin
          state_nxt = ST_MUL_C;
        end
      end
      ST_MUL_C: begin
        cmd.mul_colour = 1'b1;
        state_nxt      = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_bright = 1'b1;
        state_nxt      = ST_READ;
      end
      ST_READ: begin
        cmd.read_entry = 1'b1;
        state_nxt      = ST_SHADE;
      end
      ST_SHADE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("result emitted while the output register was occupied");

  a_pixel_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.in_ready && st.in_valid && st.is_pixel) |=> (state_r == ST_MUL_C))
    else $error("accepted pixel item did not start the colour scaling");

endmodule

`default_nettype wire

// ----- src/cbs_dp.sv -----
// ----------------------------------------------------------------------------
// Colour map shading datapath
// Holds the configuration registers, the palette memory, the shared scaling
// multiplier, the shading multipliers, the position counters and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  cbs_cfg_if.sink                cfg_s,
  cbs_in_if.sink                 in_s,
  cbs_out_if.source              out_s,
  input  wire cbs_pkg::cbs_cmd_t cmd,
  output cbs_pkg::cbs_status_t   st
);
  import cbs_pkg::*;

  logic [31:0] colour_min_r;
  logic [31:0] colour_scale_r;
  logic [31:0] bright_min_r;
  logic [31:0] bright_scale_r;
  logic [7:0]  top_index_r;
  logic [15:0] image_width_r;
  logic [15:0] image_height_r;

  logic [23:0] palette [PALETTE_DEPTH];

  logic        capture;
  logic [32:0] dc_r;
  logic [32:0] db_r;
  logic        dc_pos;
  logic        db_pos;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod_r;
  logic [31:0] idx_wide;
  logic [PAL_AW-1:0] idx_r;
  logic [23:0] entry_r;
  logic [32:0] bri_r;
  logic [32:0] bri_nxt;
  logic [40:0] red_p;
  logic [40:0] green_p;
  logic [40:0] blue_p;

  logic [15:0] column_r;
  logic [15:0] row_r;
  logic [15:0] column_nxt;
  logic [15:0] row_nxt;
  logic        row_wrap;
  logic        col_wrap;

  logic        out_valid_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [15:0] out_column_r;
  logic [15:0] out_row_r;
  logic        frame_end_r;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_min_r   <= '0;
      colour_scale_r <= SCALE_ONE_Q16;
      bright_min_r   <= '0;
      bright_scale_r <= SCALE_ONE_Q16;
      top_index_r    <= 8'hFF;
      image_width_r  <= 16'd1;
      image_height_r <= 16'd1;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_COLOUR_MIN:   colour_min_r   <= cfg_s.data;
        REG_COLOUR_SCALE: colour_scale_r <= cfg_s.data;
        REG_BRIGHT_MIN:   bright_min_r   <= cfg_s.data;
        REG_BRIGHT_SCALE: bright_scale_r <= cfg_s.data;
        REG_TOP_INDEX:    top_index_r    <= cfg_s.data[7:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_s.data[15:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_s.data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_s.ready  = cmd.in_ready;
  assign capture     = in_s.valid && cmd.in_ready;
  assign st.in_valid = in_s.valid;
  assign st.is_pixel = (in_s.operation == OP_SHADE);
  assign st.out_free = !out_valid_r || out_s.ready;

  // Palette write on a load item.
  always_ff @(posedge clk) begin
    if (capture && (in_s.operation == OP_LOAD) &&
        ({24'd0, in_s.entry_index} < 32'(PALETTE_DEPTH))) begin
      palette[PAL_AW'(in_s.entry_index)] <=
        {in_s.entry_red, in_s.entry_green, in_s.entry_blue};
    end
  end

  // Palette read, registered.
  always_ff @(posedge clk) begin
    if (cmd.read_entry) begin
      entry_r <= palette[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      dc_r <= {in_s.colour_value[31], in_s.colour_value} -
              {colour_min_r[31], colour_min_r};
      db_r <= {in_s.bright_value[31], in_s.bright_value} -
              {bright_min_r[31], bright_min_r};
    end
  end

  assign dc_pos = !dc_r[32] && (dc_r != '0);
  assign db_pos = !db_r[32] && (db_r != '0);

  assign mul_a = cmd.mul_bright ? db_r[31:0] : dc_r[31:0];
  assign mul_b = cmd.mul_bright ? bright_scale_r : colour_scale_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_colour || cmd.mul_bright) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
  end

  always_comb begin
    idx_wide = '0;
    if (dc_pos) begin
      idx_wide = prod_r[63:32];
      if (idx_wide > {24'd0, top_index_r}) begin
        idx_wide = {24'd0, top_index_r};
      end
      if (idx_wide > 32'(PALETTE_DEPTH - 1)) begin
        idx_wide = 32'(PALETTE_DEPTH - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_bright) begin
      idx_r <= PAL_AW'(idx_wide);
    end
  end

  always_comb begin
    bri_nxt = '0;
    if (db_pos) begin
      if (prod_r > {31'd0, BRIGHT_FULL}) begin
        bri_nxt = BRIGHT_FULL;
      end else begin
        bri_nxt = prod_r[32:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_entry) begin
      bri_r <= bri_nxt;
    end
  end

  assign red_p   = 41'(bri_r) * 41'(entry_r[23:16]);
  assign green_p = 41'(bri_r) * 41'(entry_r[15:8]);
  assign blue_p  = 41'(bri_r) * 41'(entry_r[7:0]);

  assign row_wrap = ({1'b0, row_r} + 17'd1) >= {1'b0, image_height_r};
  assign col_wrap = ({1'b0, column_r} + 17'd1) >= {1'b0, image_width_r};

  always_comb begin
    row_nxt    = row_r;
    column_nxt = column_r;
    if (row_wrap) begin
      row_nxt    = '0;
      column_nxt = col_wrap ? 16'd0 : column_r + 16'd1;
    end else begin
      row_nxt = row_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        column_r    <= column_nxt;
        row_r       <= row_nxt;
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red_r        <= red_p[39:32];
      green_r      <= green_p[39:32];
      blue_r       <= blue_p[39:32];
      out_column_r <= column_r;
      out_row_r    <= row_r;
      frame_end_r  <= row_wrap && col_wrap;
    end
  end

  assign out_s.valid     = out_valid_r;
  assign out_s.red       = red_r;
  assign out_s.green     = green_r;
  assign out_s.blue      = blue_r;
  assign out_s.column    = out_column_r;
  assign out_s.row       = out_row_r;
  assign out_s.frame_end = frame_end_r;

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result is not presented on the output");

  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.read_entry) |-> (bri_r <= BRIGHT_FULL))
    else $error("brightness factor exceeds full scale");

endmodule

`default_nettype wire

// ----- tb/sv/colormap_brightness_shade_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map brightness shading testbench
// The testbench streams palette loads and pixels through the block under
// several register settings. Each pixel is predicted from the palette and
// the registers, and each result is compared field by field, in order.
// ----------------------------------------------------------------------------
module colormap_brightness_shade_test;
  import cbs_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned IDLE_PERCENT    = 19;
  localparam int unsigned ITEMS_PER_PHASE = 180;
  localparam int unsigned MAX_REPORTS     = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic        operation;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [31:0] colour_value;
    logic [31:0] bright_value;
  } item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] column;
    logic [15:0] row;
    logic        frame_end;
  } pixel_t;

  typedef struct packed {
    logic [31:0] colour_min;
    logic [31:0] colour_scale;
    logic [31:0] bright_min;
    logic [31:0] bright_scale;
    logic [7:0]  top_index;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } regs_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cbs_cfg_if cfg_bus ();
  cbs_in_if  in_bus ();
  cbs_out_if out_bus ();

  colormap_brightness_shade i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_bus),
    .in_s  (in_bus),
    .out_s (out_bus)
  );

  regs_t       regs;
  logic [23:0] palette [PALETTE_DEPTH];
  bit          loaded [PALETTE_DEPTH];
  logic [15:0] col_pos = '0;
  logic [15:0] row_pos = '0;
  item_t       pending_items [$];
  pixel_t      shade_q [$];

  int unsigned items_pushed = 0;
  int unsigned items_taken  = 0;
  int unsigned pixels_seen  = 0;
  int unsigned loads_taken  = 0;
  int unsigned frames_seen  = 0;
  int unsigned reg_writes   = 0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;
  int unsigned hold_left    = 0;
  logic        in_fire      = 1'b0;
  logic        calm         = 1'b0;
  logic        hold_phase   = 1'b0;
  logic        hold_done    = 1'b0;

  always #10 clk = ~clk;

  // (value - low) * scale as unsigned Q32.32, zero when value is not above low.
  function automatic logic [63:0] offset_times_scale(logic [31:0] value, logic [31:0] low,
                                                     logic [31:0] scale);
    logic signed [32:0] diff;
    diff = $signed({value[31], value}) - $signed({low[31], low});
    if (diff <= 0) return 64'd0;
    return {31'd0, diff} * {32'd0, scale};
  endfunction

  function automatic logic [7:0] palette_slot(logic [31:0] colour);
    logic [63:0] p;
    logic [31:0] slot;
    p = offset_times_scale(colour, regs.colour_min, regs.colour_scale);
    slot = p[63:32];
    if (slot > {24'd0, regs.top_index}) slot = {24'd0, regs.top_index};
    if (slot > PALETTE_DEPTH - 1) slot = PALETTE_DEPTH - 1;
    return slot[7:0];
  endfunction

  function automatic logic [32:0] brightness(logic [31:0] bright);
    logic [63:0] b;
    b = offset_times_scale(bright, regs.bright_min, regs.bright_scale);
    if (b > {31'd0, BRIGHT_FULL}) b = {31'd0, BRIGHT_FULL};
    return b[32:0];
  endfunction

  function automatic logic [7:0] dim(logic [32:0] b, logic [7:0] channel);
    logic [63:0] prod;
    prod = {31'd0, b} * {56'd0, channel};
    return prod[39:32];
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("pixel %0d %s: got %0h, expected %0h",
                             pixels_seen, name, got, want));
  endtask

  task automatic take_item(item_t it);
    pixel_t      px;
    logic [23:0] entry;
    logic [32:0] b;
    logic        row_wrap;
    logic        col_wrap;
    if (it.operation == OP_LOAD) begin
      palette[it.entry_index] = {it.entry_red, it.entry_green, it.entry_blue};
      loads_taken++;
    end else begin
      entry = palette[palette_slot(it.colour_value)];
      b = brightness(it.bright_value);
      px.red    = dim(b, entry[23:16]);
      px.green  = dim(b, entry[15:8]);
      px.blue   = dim(b, entry[7:0]);
      px.column = col_pos;
      px.row    = row_pos;
      row_wrap  = ({1'b0, row_pos} + 17'd1) >= {1'b0, regs.image_height};
      col_wrap  = ({1'b0, col_pos} + 17'd1) >= {1'b0, regs.image_width};
      px.frame_end = row_wrap && col_wrap;
      if (row_wrap) begin
        row_pos = '0;
        col_pos = col_wrap ? 16'd0 : col_pos + 16'd1;
      end else begin
        row_pos = row_pos + 16'd1;
      end
      shade_q.push_back(px);
    end
  endtask

  task automatic push_load(logic [7:0] slot, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    item_t it;
    it.operation    = OP_LOAD;
    it.entry_index  = slot;
    it.entry_red    = r;
    it.entry_green  = g;
    it.entry_blue   = b;
    it.colour_value = $urandom;
    it.bright_value = $urandom;
    loaded[slot] = 1'b1;
    pending_items.push_back(it);
    items_pushed++;
  endtask

  // A pixel never reads an entry that has not been loaded since reset.
  task automatic push_pixel(logic [31:0] colour, logic [31:0] bright);
    item_t      it;
    logic [7:0] slot;
    slot = palette_slot(colour);
    if (!loaded[slot]) push_load(slot, 8'($urandom), 8'($urandom), 8'($urandom));
    it.operation    = OP_SHADE;
    it.entry_index  = 8'($urandom);
    it.entry_red    = 8'($urandom);
    it.entry_green  = 8'($urandom);
    it.entry_blue   = 8'($urandom);
    it.colour_value = colour;
    it.bright_value = bright;
    pending_items.push_back(it);
    items_pushed++;
  endtask

  task automatic push_random_pixel();
    logic [63:0]  span;
    logic [31:0]  colour;
    logic [31:0]  bright;
    int unsigned  pick;
    span = (regs.colour_scale == 0) ? 64'hFFFF_FFFF :
           (({56'd0, regs.top_index} + 64'd2) << 32) / regs.colour_scale;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    pick = $urandom_range(0, 99);
    if (pick < 20) colour = $urandom;
    else if (pick < 30) colour = regs.colour_min - $urandom_range(0, 32'hFFFF);
    else colour = regs.colour_min + $urandom_range(0, span[31:0]);
    span = (regs.bright_scale == 0) ? 64'hFFFF_FFFF : 64'h1_4000_0000 / regs.bright_scale;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    pick = $urandom_range(0, 99);
    if (pick < 20) bright = $urandom;
    else if (pick < 30) bright = regs.bright_min - $urandom_range(0, 32'hFFFF);
    else bright = regs.bright_min + $urandom_range(0, span[31:0]);
    push_pixel(colour, bright);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_COLOUR_MIN:   regs.colour_min   = value;
      REG_COLOUR_SCALE: regs.colour_scale = value;
      REG_BRIGHT_MIN:   regs.bright_min   = value;
      REG_BRIGHT_SCALE: regs.bright_scale = value;
      REG_TOP_INDEX:    regs.top_index    = value[7:0];
      REG_IMAGE_WIDTH:  regs.image_width  = value[15:0];
      REG_IMAGE_HEIGHT: regs.image_height = value[15:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || items_taken != items_pushed || shade_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(regs_t r, logic quiet, logic hold, int unsigned count);
    write_reg(REG_COLOUR_MIN,   r.colour_min);
    write_reg(REG_COLOUR_SCALE, r.colour_scale);
    write_reg(REG_BRIGHT_MIN,   r.bright_min);
    write_reg(REG_BRIGHT_SCALE, r.bright_scale);
    write_reg(REG_TOP_INDEX,    {24'd0, r.top_index});
    write_reg(REG_IMAGE_WIDTH,  {16'd0, r.image_width});
    write_reg(REG_IMAGE_HEIGHT, {16'd0, r.image_height});
    @(posedge clk);
    calm = quiet;
    hold_phase = hold;
    repeat (count) begin
      if ($urandom_range(0, 99) < 15)
        push_load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else push_random_pixel();
    end
    wait_idle();
    calm = 1'b0;
    hold_phase = 1'b0;
  endtask

  always @(negedge clk) begin : feed
    item_t nxt;
    if (rst_n && (!in_bus.valid || in_fire)) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        nxt = pending_items.pop_front();
        in_bus.valid        <= 1'b1;
        in_bus.operation    <= nxt.operation;
        in_bus.entry_index  <= nxt.entry_index;
        in_bus.entry_red    <= nxt.entry_red;
        in_bus.entry_green  <= nxt.entry_green;
        in_bus.entry_blue   <= nxt.entry_blue;
        in_bus.colour_value <= nxt.colour_value;
        in_bus.bright_value <= nxt.bright_value;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drain
    if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_phase && !hold_done && shade_q.size() != 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin : watch
    item_t  it;
    pixel_t got;
    pixel_t want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end else begin
      in_fire <= rst_n && in_bus.valid && in_bus.ready;
      if (rst_n && in_bus.valid && in_bus.ready) begin
        it = '{in_bus.operation, in_bus.entry_index, in_bus.entry_red, in_bus.entry_green,
               in_bus.entry_blue, in_bus.colour_value, in_bus.bright_value};
        take_item(it);
        items_taken++;
      end
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got = '{out_bus.red, out_bus.green, out_bus.blue, out_bus.column, out_bus.row,
                out_bus.frame_end};
        if (shade_q.size() == 0) begin
          report_error($sformatf("pixel %0d arrived with none outstanding", pixels_seen));
        end else begin
          want = shade_q.pop_front();
          check_field("red", 16'(got.red), 16'(want.red));
          check_field("green", 16'(got.green), 16'(want.green));
          check_field("blue", 16'(got.blue), 16'(want.blue));
          check_field("column", got.column, want.column);
          check_field("row", got.row, want.row);
          check_field("frame_end", 16'(got.frame_end), 16'(want.frame_end));
        end
        pixels_seen++;
        if (got.frame_end === 1'b1) frames_seen++;
      end
    end
  end

  initial begin : stimulus
    regs_t r;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_COLOUR_MIN;
    cfg_bus.data        = '0;
    in_bus.valid        = 1'b0;
    in_bus.operation    = OP_LOAD;
    in_bus.entry_index  = '0;
    in_bus.entry_red    = '0;
    in_bus.entry_green  = '0;
    in_bus.entry_blue   = '0;
    in_bus.colour_value = '0;
    in_bus.bright_value = '0;
    out_bus.ready       = 1'b0;
    regs = '{colour_min: 32'd0, colour_scale: SCALE_ONE_Q16, bright_min: 32'd0,
             bright_scale: SCALE_ONE_Q16, top_index: 8'd255, image_width: 16'd1,
             image_height: 16'd1};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes under the reset settings: clamping at both ends of the colour
    // range, truncation of the index, brightness at, below and above full.
    push_load(8'd0, 8'hFF, 8'hFF, 8'hFF);
    push_load(8'd255, 8'h80, 8'h01, 8'hFE);
    push_load(8'd7, 8'h12, 8'h34, 8'h56);
    push_load(8'd1, 8'hAA, 8'h55, 8'h0F);
    push_pixel(32'h8000_0000, 32'h7FFF_FFFF);
    push_pixel(32'h7FFF_FFFF, 32'h0001_0000);
    push_pixel(32'h0000_0000, 32'h0000_FFFF);
    push_pixel(32'h0000_FFFF, 32'h0001_0001);
    push_pixel(32'h0001_0000, 32'h8000_0000);
    push_pixel(32'h0007_8000, 32'h0000_8000);
    push_pixel(32'h00FF_0000, 32'h0000_0000);
    push_pixel(32'h0100_0000, 32'h0000_0001);
    push_load(8'd7, 8'h00, 8'hFF, 8'h00);
    push_pixel(32'h0007_0000, 32'h0000_C000);
    push_load(8'd255, 8'hFF, 8'h00, 8'hFF);
    push_pixel(32'h7FFF_0000, 32'h0000_4000);
    wait_idle();

    r = '{colour_min: $urandom, colour_scale: 32'h00FF_0000, bright_min: $urandom,
          bright_scale: SCALE_ONE_Q16, top_index: 8'd255, image_width: 16'd4,
          image_height: 16'd3};
    run_phase(r, 1'b1, 1'b0, ITEMS_PER_PHASE);

    r = '{colour_min: 32'd0, colour_scale: 32'h0010_0000, bright_min: 32'd0,
          bright_scale: 32'h0000_8000, top_index: 8'd200, image_width: 16'd0,
          image_height: 16'd0};
    run_phase(r, 1'b0, 1'b1, ITEMS_PER_PHASE);

    r = '{colour_min: 32'h8000_0000, colour_scale: 32'hFFFF_FFFF, bright_min: 32'h8000_0000,
          bright_scale: 32'hFFFF_FFFF, top_index: 8'd0, image_width: 16'hFFFF,
          image_height: 16'hFFFF};
    run_phase(r, 1'b0, 1'b0, ITEMS_PER_PHASE);

    // The counters are left well beyond the new size and must wrap.
    r = '{colour_min: $urandom, colour_scale: $urandom_range(32'h100, 32'h0100_0000),
          bright_min: $urandom, bright_scale: $urandom_range(32'h100, 32'h0100_0000),
          top_index: 8'($urandom_range(1, 255)), image_width: 16'd2, image_height: 16'd3};
    run_phase(r, 1'b0, 1'b0, ITEMS_PER_PHASE);

    r = '{colour_min: 32'h7FFF_FFFF, colour_scale: 32'd0, bright_min: 32'h7FFF_FFFF,
          bright_scale: 32'd0, top_index: 8'd255, image_width: 16'd1, image_height: 16'd1};
    run_phase(r, 1'b0, 1'b0, 60);

    write_reg(REG_UNUSED, $urandom);
    repeat (3) begin
      r = '{colour_min: $urandom, colour_scale: $urandom_range(32'h100, 32'h0100_0000),
            bright_min: $urandom, bright_scale: $urandom_range(32'h100, 32'h0100_0000),
            top_index: 8'($urandom_range(1, 255)),
            image_width: 16'($urandom_range(1, 6)),
            image_height: 16'($urandom_range(1, 6))};
      run_phase(r, 1'b0, 1'b0, 200);
    end

    $display("Shaded %0d pixels, %0d of them closing a frame, with %0d palette loads.",
             pixels_seen, frames_seen, loads_taken);
    $display("Used %0d register writes, zero and full scales, zero to maximum image sizes.",
             reg_writes);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- colormap_brightness_shade.f -----
src/cbs_pkg.sv
src/cbs_in_if.sv
src/cbs_out_if.sv
src/cbs_cfg_if.sv
src/cbs_ctrl.sv
src/cbs_dp.sv
src/colormap_brightness_shade.sv
tb/sv/colormap_brightness_shade_test.sv
